// File: sv/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared constants for the trilinear voxel sampler: field widths, stream
// packing, command and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tvs_pkg;

  localparam int VOX_W    = 8;
  localparam int ADDR_W   = 15;
  localparam int POS_W    = 16;
  localparam int CRD_W    = 6;
  localparam int EXT_W    = 6;
  localparam int SAMPLE_W = 16;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  localparam int IDX_LSB  = 0;
  localparam int VAL_LSB  = IDX_LSB + ADDR_W;
  localparam int POSX_LSB = VAL_LSB + VOX_W;
  localparam int POSY_LSB = POSX_LSB + POS_W;
  localparam int POSZ_LSB = POSY_LSB + POS_W;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] REG_EXTENT_X = 2'd0;
  localparam logic [1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [1:0] REG_EXTENT_Z = 2'd2;

  localparam logic [EXT_W-1:0] EXTENT_RST = 6'd32;

endpackage

`default_nettype wire

// File: sv/tvs_split.sv
// ----------------------------------------------------------------------------
// tvs_split
// Splits one fixed-point position into clamped lower/upper corner
// coordinates and the blend fraction, after the half-voxel offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_split #(
  parameter int POS_FRAC_BITS = 8
) (
  input  wire logic signed [tvs_pkg::POS_W-1:0] pos,
  input  wire logic [tvs_pkg::EXT_W-1:0]        ext,
  output logic [tvs_pkg::CRD_W-1:0]             lo,
  output logic [tvs_pkg::CRD_W-1:0]             hi,
  output logic [POS_FRAC_BITS-1:0]              frac
);

  localparam int HALF = 1 << (POS_FRAC_BITS - 1);

  logic signed [16:0] v;
  logic signed [16:0] fl;
  logic signed [17:0] fl0;
  logic signed [17:0] fl1;

  function automatic logic [tvs_pkg::CRD_W-1:0] clamp_c(
    input logic signed [17:0]       c,
    input logic [tvs_pkg::EXT_W-1:0] e
  );
    logic signed [17:0] top;
    top = $signed({12'b0, e}) - 18'sd1;
    if (c < 18'sd0) begin
      return '0;
    end else if (c > top) begin
      return top[tvs_pkg::CRD_W-1:0];
    end else begin
      return c[tvs_pkg::CRD_W-1:0];
    end
  endfunction

  assign v    = $signed({pos[tvs_pkg::POS_W-1], pos}) - $signed(17'(HALF));
  assign fl   = v >>> POS_FRAC_BITS;
  assign fl0  = $signed({fl[16], fl});
  assign fl1  = fl0 + 18'sd1;
  assign frac = v[POS_FRAC_BITS-1:0];
  assign lo   = clamp_c(fl0, ext);
  assign hi   = clamp_c(fl1, ext);

endmodule

`default_nettype wire

// File: sv/tvs_lerp.sv
// ----------------------------------------------------------------------------
// tvs_lerp
// Shared blend unit: a*(2^F - f) + b*f computed as (a << F) + (b - a)*f
// with a single signed multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_lerp #(
  parameter int POS_FRAC_BITS = 8,
  parameter int OPND_W        = 24
) (
  input  wire logic [OPND_W-1:0]        a,
  input  wire logic [OPND_W-1:0]        b,
  input  wire logic [POS_FRAC_BITS-1:0] f,
  output logic [OPND_W+POS_FRAC_BITS-1:0] y
);

  localparam int P = OPND_W + POS_FRAC_BITS + 2;

  logic signed [OPND_W:0] diff;
  logic signed [P-1:0]    diff_x;
  logic signed [P-1:0]    f_x;
  logic signed [P-1:0]    a_sh;
  logic signed [P-1:0]    prod;
  logic signed [P-1:0]    sum;

  assign diff   = $signed({1'b0, b}) - $signed({1'b0, a});
  assign diff_x = $signed({{(POS_FRAC_BITS+1){diff[OPND_W]}}, diff});
  assign f_x    = $signed({{(OPND_W+2){1'b0}}, f});
  assign a_sh   = $signed({2'b00, a, {POS_FRAC_BITS{1'b0}}});
  assign prod   = diff_x * f_x;
  assign sum    = a_sh + prod;
  assign y      = sum[OPND_W+POS_FRAC_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/trilinear_voxel_sampler_core.sv
// ----------------------------------------------------------------------------
// trilinear_voxel_sampler_core
// 32K x 8 voxel store with clamp-to-edge trilinear sampling.
// ----------------------------------------------------------------------------
// A load request (tuser = 0) writes one voxel and leaves the block ready for
// the next request. A sample request (tuser = 1) passes from acceptance through
// ST_SPLIT to split the position, ST_ROW for the z row bases, ST_READ for the
// eight corner reads through the single-port voxel memory, ST_BLEND for seven
// blends through the one shared lerp multiplier and ST_DONE for rounding into
// the output register. in_tready is low while a sample is in progress. The
// output register holds one result, so a new request is taken while that
// result waits; a following sample then holds in ST_DONE until the result
// is taken. The store has no reset; sampling a voxel never loaded returns an
// undefined value. The user must write extents over the APB port only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_voxel_sampler_core #(
  parameter int DIM_MAX       = 32,
  parameter int POS_FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [14:0] voxel_index, [22:15] voxel_value, [38:23] pos_x, [54:39] pos_y,
  // [70:55] pos_z, [71] zero
  input  wire logic [tvs_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] cmd
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] sample
  output logic [tvs_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [tvs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [tvs_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tvs_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int F     = POS_FRAC_BITS;
  localparam int MID_W = tvs_pkg::VOX_W + F;
  localparam int PR_W  = tvs_pkg::VOX_W + 2 * F;
  localparam int SUM_W = tvs_pkg::VOX_W + 3 * F;
  localparam int SH    = 3 * F - 8;
  localparam int DEPTH = 1 << tvs_pkg::ADDR_W;
  localparam int CW    = tvs_pkg::CRD_W;
  localparam int EW    = tvs_pkg::EXT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_ROW,
    ST_READ,
    ST_BLEND,
    ST_DONE
  } state_t;

  state_t state_r;
  logic [3:0] step_r;

  logic [EW-1:0] ext_x_r, ext_y_r, ext_z_r;
  logic [EW-1:0] nx, ny, nz;
  logic          cfg_wr;

  logic signed [tvs_pkg::POS_W-1:0] px_r, py_r, pz_r;
  logic [CW-1:0] x0, x1, y0, y1, z0, z1;
  logic [F-1:0]  fx, fy, fz;
  logic [CW-1:0] x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [F-1:0]  fx_r, fy_r, fz_r;
  logic [11:0]   rz0_r, rz1_r;

  logic [tvs_pkg::VOX_W-1:0] mem [0:DEPTH-1];
  logic [tvs_pkg::VOX_W-1:0] rd_r;
  logic [tvs_pkg::ADDR_W-1:0] rd_addr;
  logic [11:0] row;
  logic [17:0] lin;
  logic [CW-1:0] xs, ys;
  logic [11:0] rzs;

  logic [tvs_pkg::VOX_W-1:0] vox_r [0:7];
  logic [MID_W-1:0] mid_r [0:3];
  logic [PR_W-1:0]  pair_r [0:1];
  logic [SUM_W-1:0] sum_r;

  logic [PR_W-1:0]  la, lb;
  logic [F-1:0]     lf;
  logic [PR_W+F-1:0] ly;
  logic [SUM_W:0]   rnd;

  logic in_acc;
  logic ld_acc;
  logic out_load;

  function automatic logic [EW-1:0] eff_extent(input logic [EW-1:0] r);
    logic [EW-1:0] e;
    e = r;
    if (e == '0) begin
      e = EW'(1);
    end
    if (32'(e) > DIM_MAX) begin
      e = EW'(DIM_MAX);
    end
    return e;
  endfunction

  assign nx = eff_extent(ext_x_r);
  assign ny = eff_extent(ext_y_r);
  assign nz = eff_extent(ext_z_r);

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= tvs_pkg::EXTENT_RST;
      ext_y_r <= tvs_pkg::EXTENT_RST;
      ext_z_r <= tvs_pkg::EXTENT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        tvs_pkg::REG_EXTENT_X: ext_x_r <= cfg_pwdata[EW-1:0];
        tvs_pkg::REG_EXTENT_Y: ext_y_r <= cfg_pwdata[EW-1:0];
        tvs_pkg::REG_EXTENT_Z: ext_z_r <= cfg_pwdata[EW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      tvs_pkg::REG_EXTENT_X: cfg_prdata = {26'b0, ext_x_r};
      tvs_pkg::REG_EXTENT_Y: cfg_prdata = {26'b0, ext_y_r};
      tvs_pkg::REG_EXTENT_Z: cfg_prdata = {26'b0, ext_z_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // axis split
  tvs_split #(.POS_FRAC_BITS(F)) u_split_x (.pos(px_r), .ext(nx), .lo(x0), .hi(x1), .frac(fx));
  tvs_split #(.POS_FRAC_BITS(F)) u_split_y (.pos(py_r), .ext(ny), .lo(y0), .hi(y1), .frac(fy));
  tvs_split #(.POS_FRAC_BITS(F)) u_split_z (.pos(pz_r), .ext(nz), .lo(z0), .hi(z1), .frac(fz));

  // corner address, corner k: bit 0 selects x, bit 1 y, bit 2 z
  assign xs      = step_r[0] ? x1_r : x0_r;
  assign ys      = step_r[1] ? y1_r : y0_r;
  assign rzs     = step_r[2] ? rz1_r : rz0_r;
  assign row     = rzs + {6'b0, ys};
  assign lin     = 18'({6'b0, row} * {12'b0, nx}) + {12'b0, xs};
  assign rd_addr = lin[tvs_pkg::ADDR_W-1:0];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ld_acc    = in_acc && (in_tuser == tvs_pkg::CMD_LOAD);
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid || out_tready);

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      mem[in_tdata[tvs_pkg::IDX_LSB +: tvs_pkg::ADDR_W]] <=
        in_tdata[tvs_pkg::VAL_LSB +: tvs_pkg::VOX_W];
    end
    rd_r <= mem[rd_addr];
  end

  // blend operands: x pairs, then y pairs, then the z pair
  always_comb begin
    if (step_r < 4'd4) begin
      la = PR_W'(vox_r[0]);
      lb = PR_W'(vox_r[1]);
      lf = fx_r;
    end else if (step_r < 4'd6) begin
      la = PR_W'(mid_r[0]);
      lb = PR_W'(mid_r[1]);
      lf = fy_r;
    end else begin
      la = pair_r[0];
      lb = pair_r[1];
      lf = fz_r;
    end
  end

  tvs_lerp #(.POS_FRAC_BITS(F), .OPND_W(PR_W)) u_lerp (
    .a(la), .b(lb), .f(lf), .y(ly)
  );

  assign rnd = {1'b0, sum_r} + (SUM_W+1)'(1 << (SH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == tvs_pkg::CMD_SAMPLE)) begin
            px_r    <= $signed(in_tdata[tvs_pkg::POSX_LSB +: tvs_pkg::POS_W]);
            py_r    <= $signed(in_tdata[tvs_pkg::POSY_LSB +: tvs_pkg::POS_W]);
            pz_r    <= $signed(in_tdata[tvs_pkg::POSZ_LSB +: tvs_pkg::POS_W]);
            state_r <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          x0_r <= x0; x1_r <= x1;
          y0_r <= y0; y1_r <= y1;
          z0_r <= z0; z1_r <= z1;
          fx_r <= fx; fy_r <= fy; fz_r <= fz;
          state_r <= ST_ROW;
        end
        ST_ROW: begin
          rz0_r   <= 12'({6'b0, z0_r} * {6'b0, ny});
          rz1_r   <= 12'({6'b0, z1_r} * {6'b0, ny});
          step_r  <= '0;
          state_r <= ST_READ;
        end
        ST_READ: begin
          if (step_r != 4'd0) begin
            for (int i = 0; i < 7; i++) begin
              vox_r[i] <= vox_r[i+1];
            end
            vox_r[7] <= rd_r;
          end
          if (step_r == 4'd8) begin
            step_r  <= '0;
            state_r <= ST_BLEND;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        ST_BLEND: begin
          if (step_r < 4'd4) begin
            for (int i = 0; i < 6; i++) begin
              vox_r[i] <= vox_r[i+2];
            end
            for (int i = 0; i < 3; i++) begin
              mid_r[i] <= mid_r[i+1];
            end
            mid_r[3] <= ly[MID_W-1:0];
          end else if (step_r < 4'd6) begin
            mid_r[0]  <= mid_r[2];
            mid_r[1]  <= mid_r[3];
            pair_r[0] <= pair_r[1];
            pair_r[1] <= ly[PR_W-1:0];
          end else begin
            sum_r <= ly[SUM_W-1:0];
          end
          if (step_r == 4'd6) begin
            state_r <= ST_DONE;
          end
          step_r <= step_r + 4'd1;
        end
        ST_DONE: begin
          if (out_load) begin
            out_tdata  <= rnd[SH +: tvs_pkg::SAMPLE_W];
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/tvs_checker.sv
// ----------------------------------------------------------------------------
// tvs_checker
// Port-level checks for the trilinear voxel sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tvs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // sample range tops out at 255.0
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'hFF00)
    else $error("sample above full scale");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == tvs_pkg::CMD_SAMPLE) |=> !in_tready)
    else $error("ready after sample request");

  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == tvs_pkg::CMD_LOAD) |=> in_tready)
    else $error("load request stalled input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind trilinear_voxel_sampler_core tvs_checker u_tvs_checker (.*);

`default_nettype wire

// File: tb/tvs_sample_checker.sv
// ----------------------------------------------------------------------------
// tvs_sample_checker
// Watches the request, result and APB channels of the voxel sampler. It keeps
// its own voxel store and extent registers, predicts every sample and compares
// each result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_sample_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [tvs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [tvs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [tvs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [tvs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  wire logic                           cfg_pready,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  n_loads,
  output int                                  n_samples,
  output int                                  n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC     = 8;
  localparam int DIM_LIM  = 32;
  localparam int RND_SH   = 3 * FRAC - 8;

  logic [tvs_pkg::VOX_W-1:0]    vox_mem [0:(1<<tvs_pkg::ADDR_W)-1];
  logic [tvs_pkg::EXT_W-1:0]    ext_x, ext_y, ext_z;
  logic [tvs_pkg::SAMPLE_W-1:0] sample_due_q [$];

  initial begin
    foreach (vox_mem[i]) vox_mem[i] = '0;
    ext_x = tvs_pkg::EXTENT_RST;
    ext_y = tvs_pkg::EXTENT_RST;
    ext_z = tvs_pkg::EXTENT_RST;
  end

  function automatic int span_of(input logic [tvs_pkg::EXT_W-1:0] r);
    int e;
    e = int'(r);
    if (e < 1) e = 1;
    if (e > DIM_LIM) e = DIM_LIM;
    return e;
  endfunction

  // half-voxel shift, floor, clamp-to-edge
  function automatic void split_axis(input logic signed [tvs_pkg::POS_W-1:0] p,
                                     input int n,
                                     output int lo, output int hi, output int fr);
    int v, fl;
    v  = int'(p) - (1 << (FRAC - 1));
    fl = v >>> FRAC;
    fr = v & ((1 << FRAC) - 1);
    lo = (fl < 0) ? 0 : (fl > n - 1) ? n - 1 : fl;
    hi = (fl + 1 < 0) ? 0 : (fl + 1 > n - 1) ? n - 1 : fl + 1;
  endfunction

  function automatic longint unsigned voxel_at(input int x, input int y, input int z,
                                               input int nx, input int ny);
    int a;
    a = ((z * ny + y) * nx + x) & ((1 << tvs_pkg::ADDR_W) - 1);
    return longint'(vox_mem[a[tvs_pkg::ADDR_W-1:0]]);
  endfunction

  function automatic longint unsigned lerp(input longint unsigned a,
                                           input longint unsigned b, input int f);
    return a * longint'((1 << FRAC) - f) + b * longint'(f);
  endfunction

  function automatic logic [tvs_pkg::SAMPLE_W-1:0] trilerp_sample(
    input logic signed [tvs_pkg::POS_W-1:0] px,
    input logic signed [tvs_pkg::POS_W-1:0] py,
    input logic signed [tvs_pkg::POS_W-1:0] pz
  );
    int nx, ny, nz, x0, x1, y0, y1, z0, z1, fx, fy, fz;
    longint unsigned a0, a1, a2, a3, b0, b1, sum;
    nx = span_of(ext_x);
    ny = span_of(ext_y);
    nz = span_of(ext_z);
    split_axis(px, nx, x0, x1, fx);
    split_axis(py, ny, y0, y1, fy);
    split_axis(pz, nz, z0, z1, fz);
    a0  = lerp(voxel_at(x0, y0, z0, nx, ny), voxel_at(x1, y0, z0, nx, ny), fx);
    a1  = lerp(voxel_at(x0, y1, z0, nx, ny), voxel_at(x1, y1, z0, nx, ny), fx);
    a2  = lerp(voxel_at(x0, y0, z1, nx, ny), voxel_at(x1, y0, z1, nx, ny), fx);
    a3  = lerp(voxel_at(x0, y1, z1, nx, ny), voxel_at(x1, y1, z1, nx, ny), fx);
    b0  = lerp(a0, a1, fy);
    b1  = lerp(a2, a3, fy);
    sum = lerp(b0, b1, fz);
    sum = (sum + (64'd1 << (RND_SH - 1))) >> RND_SH;
    return sum[tvs_pkg::SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [tvs_pkg::SAMPLE_W-1:0] want;
    if (!rst_n) begin
      ext_x = tvs_pkg::EXTENT_RST;
      ext_y = tvs_pkg::EXTENT_RST;
      ext_z = tvs_pkg::EXTENT_RST;
      sample_due_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          tvs_pkg::REG_EXTENT_X: ext_x = cfg_pwdata[tvs_pkg::EXT_W-1:0];
          tvs_pkg::REG_EXTENT_Y: ext_y = cfg_pwdata[tvs_pkg::EXT_W-1:0];
          tvs_pkg::REG_EXTENT_Z: ext_z = cfg_pwdata[tvs_pkg::EXT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == tvs_pkg::CMD_LOAD) begin
          vox_mem[in_tdata[tvs_pkg::IDX_LSB +: tvs_pkg::ADDR_W]] =
            in_tdata[tvs_pkg::VAL_LSB +: tvs_pkg::VOX_W];
          n_loads <= n_loads + 1;
        end else begin
          sample_due_q.push_back(
            trilerp_sample(in_tdata[tvs_pkg::POSX_LSB +: tvs_pkg::POS_W],
                           in_tdata[tvs_pkg::POSY_LSB +: tvs_pkg::POS_W],
                           in_tdata[tvs_pkg::POSZ_LSB +: tvs_pkg::POS_W]));
          n_samples <= n_samples + 1;
        end
      end
      if (out_tvalid && out_tready) begin
        n_results <= n_results + 1;
        if (sample_due_q.size() == 0) begin
          $error("sample: no request outstanding, actual %0d", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = sample_due_q.pop_front();
          if (out_tdata[tvs_pkg::SAMPLE_W-1:0] !== want) begin
            $error("sample mismatch: expected %0d, actual %0d", want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= sample_due_q.size();
  end

endmodule

`default_nettype wire

// File: tb/tb_trilinear_voxel_sampler_core.sv
// ----------------------------------------------------------------------------
// tb_trilinear_voxel_sampler_core
// Drives load and sample requests with random gaps and back-pressure through
// a range of volume extents, including zero and oversized register values.
// Sample positions keep every corner inside voxels already loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trilinear_voxel_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_VOX    = 256;
  localparam int DIM_LIM    = 32;
  localparam int BOX_MAX    = 64;
  localparam int PHASES     = 20;
  localparam int PHASE_REQS = 100;
  localparam int SETTLE     = 40;
  localparam int HOLD_CYC   = 400;
  localparam int LIMIT      = 1000000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tvs_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tvs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [tvs_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [tvs_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [tvs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  int fail_count, pending, n_loads, n_samples, n_results;
  int cycles;
  int tx_calm, rx_calm;
  int n_settings;
  bit loaded [0:(1<<tvs_pkg::ADDR_W)-1];

  trilinear_voxel_sampler_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  tvs_sample_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending), .n_loads(n_loads),
    .n_samples(n_samples), .n_results(n_results)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic int span_of(input int r);
    int e;
    e = r & 63;
    if (e < 1) e = 1;
    if (e > DIM_LIM) e = DIM_LIM;
    return e;
  endfunction

  // position whose corners stay below box when box is smaller than the extent
  function automatic int pick_pos(input int n, input int b);
    int hi_lim, spread;
    hi_lim = (b < n) ? (b - 1) * ONE_VOX + ONE_VOX / 2 - 1 : 32767;
    spread = (b < n) ? hi_lim : n * ONE_VOX + 300;
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return hi_lim;
      2, 3: return -32768 + int'($urandom_range(0, hi_lim + 32768));
      default: return -300 + int'($urandom_range(0, spread + 300));
    endcase
  endfunction

  task automatic push_req(input logic cmd, input logic [tvs_pkg::ADDR_W-1:0] idx,
                          input logic [tvs_pkg::VOX_W-1:0] val,
                          input logic [tvs_pkg::POS_W-1:0] px,
                          input logic [tvs_pkg::POS_W-1:0] py,
                          input logic [tvs_pkg::POS_W-1:0] pz);
    logic [tvs_pkg::IN_DATA_W-1:0] d;
    int g;
    g = pick_gap(tx_calm);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    d = '0;
    d[tvs_pkg::IDX_LSB +: tvs_pkg::ADDR_W]  = idx;
    d[tvs_pkg::VAL_LSB +: tvs_pkg::VOX_W]   = val;
    d[tvs_pkg::POSX_LSB +: tvs_pkg::POS_W]  = px;
    d[tvs_pkg::POSY_LSB +: tvs_pkg::POS_W]  = py;
    d[tvs_pkg::POSZ_LSB +: tvs_pkg::POS_W]  = pz;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == tvs_pkg::CMD_LOAD) loaded[idx] = 1'b1;
  endtask

  task automatic cfg_write(input logic [1:0] reg_id, input int val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_id, 2'b00};
    cfg_pwdata  <= {26'($urandom()), 6'(val)};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // drain outstanding samples plus a trailing load still in the pipe
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result side: random stalls, one long hold while requests keep coming
  initial begin
    int run, g;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      if (!held && n_results >= 150 && in_tvalid) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else begin
        g = pick_gap(rx_calm);
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int plan_x [0:11];
    int plan_y [0:11];
    int plan_z [0:11];
    int rx, ry, rz, nx, ny, nz, bx, by, bz, quota, addr;
    plan_x = '{32, 1, 32, 1, 1, 5, 63, 0, 32, 3, 7, 2};
    plan_y = '{32, 1, 1, 32, 1, 3, 2, 0, 32, 32, 4, 63};
    plan_z = '{32, 1, 1, 1, 32, 3, 1, 0, 1, 32, 33, 2};
    n_settings = 1;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= tvs_pkg::CMD_LOAD;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset extents, the same x-y checkerboard on both z layers of the 2x2x2 corner block
    push_req(tvs_pkg::CMD_LOAD, 15'd0,    8'hFF, 16'h0000, 16'hFFFF, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'd1,    8'h00, 16'hFFFF, 16'h0000, 16'hFFFF);
    push_req(tvs_pkg::CMD_LOAD, 15'd32,   8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'd33,   8'hFF, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'd1024, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'd1025, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'd1056, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'd1057, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'h7FFF, 8'h80, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_LOAD, 15'h2AAA, 8'h55, 16'h0000, 16'h0000, 16'h0000);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h7FFF, 8'hFF, 16'h8000, 16'h8000, 16'h8000);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h0000, 8'h00, 16'd128, 16'd128, 16'd128);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h5555, 8'hAA, 16'd256, 16'd256, 16'd256);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h2AAA, 8'h55, 16'd383, 16'd383, 16'd383);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h0000, 8'h00, 16'd200, -16'sd5, 16'd300);

    // zero extent on x, tiny volume, positions far outside on every side
    settle();
    cfg_write(tvs_pkg::REG_EXTENT_X, 0);
    cfg_write(tvs_pkg::REG_EXTENT_Y, 1);
    cfg_write(tvs_pkg::REG_EXTENT_Z, 2);
    n_settings++;
    push_req(tvs_pkg::CMD_SAMPLE, 15'h0000, 8'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h0000, 8'h00, 16'h8000, 16'h7FFF, 16'h0000);
    push_req(tvs_pkg::CMD_SAMPLE, 15'h0000, 8'h00, 16'h7FFF, 16'h8000, 16'd192);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 12) begin
        rx = plan_x[ph];
        ry = plan_y[ph];
        rz = plan_z[ph];
      end else begin
        rx = $urandom_range(0, 63);
        ry = $urandom_range(0, 63);
        rz = $urandom_range(0, 63);
      end
      settle();
      cfg_write(tvs_pkg::REG_EXTENT_X, rx);
      cfg_write(tvs_pkg::REG_EXTENT_Y, ry);
      cfg_write(tvs_pkg::REG_EXTENT_Z, rz);
      n_settings++;
      nx = span_of(rx);
      ny = span_of(ry);
      nz = span_of(rz);
      bx = nx;
      by = ny;
      bz = nz;
      while (bx * by * bz > BOX_MAX) begin
        if (bx >= by && bx >= bz) bx = $urandom_range(1, 4);
        else if (by >= bz) by = $urandom_range(1, 4);
        else bz = $urandom_range(1, 4);
      end

      quota = PHASE_REQS;
      for (int z = 0; z < bz; z++) begin
        for (int y = 0; y < by; y++) begin
          for (int x = 0; x < bx; x++) begin
            addr = (z * ny + y) * nx + x;
            if (!loaded[addr]) begin
              push_req(tvs_pkg::CMD_LOAD, 15'(addr), 8'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()));
              quota--;
            end
          end
        end
      end
      if (quota < 40) quota = 40;

      repeat (quota) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 3) != 0)
            addr = (int'($urandom_range(0, bz - 1)) * ny + int'($urandom_range(0, by - 1)))
                   * nx + int'($urandom_range(0, bx - 1));
          else
            addr = $urandom_range(0, (1 << tvs_pkg::ADDR_W) - 1);
          push_req(tvs_pkg::CMD_LOAD, 15'(addr), 8'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()));
        end else begin
          push_req(tvs_pkg::CMD_SAMPLE, 15'($urandom()), 8'($urandom()),
                   16'(pick_pos(nx, bx)), 16'(pick_pos(ny, by)), 16'(pick_pos(nz, bz)));
        end
      end
    end

    settle();
    $display("covered %0d voxel loads and %0d samples (%0d results) over %0d extent settings",
             n_loads, n_samples, n_results, n_settings);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
